// File: rtl/uhio_pkg.sv
// shared types, constants and port bit helpers for the usb host i/o register block
`default_nettype none

package uhio_pkg;

    // defaults for the top level parameters
    localparam int unsigned NUM_PORTS_DEF   = 2;
    localparam int unsigned RESET_TICKS_DEF = 10;

    // fixed widths
    localparam int TICKS_W    = 4;
    localparam int PORT_SEL_W = 1;
    localparam int PORT_W     = 10;

    // request kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WARN  = 2'd1;
    localparam logic [1:0] ST_FATAL = 2'd2;

    // register offsets
    localparam logic [7:0] OFF_CMD    = 8'h00;
    localparam logic [7:0] OFF_STS    = 8'h02;
    localparam logic [7:0] OFF_INTR   = 8'h04;
    localparam logic [7:0] OFF_FRNUM  = 8'h06;
    localparam logic [7:0] OFF_FLBASE = 8'h08;
    localparam logic [7:0] OFF_SOF    = 8'h0C;
    localparam logic [7:0] OFF_PORT0  = 8'h10;
    localparam logic [7:0] OFF_PORT1  = 8'h12;

    // access sizes in bytes
    localparam logic [2:0] SIZE_BYTE  = 3'd1;
    localparam logic [2:0] SIZE_WORD  = 3'd2;
    localparam logic [2:0] SIZE_DWORD = 3'd4;
    localparam logic [2:0] SIZE_NONE  = 3'd0;

    // command bits
    localparam int CMD_RUN     = 0;
    localparam int CMD_HRESET  = 1;
    localparam int CMD_GRESET  = 2;
    localparam int CMD_SUSPEND = 3;
    localparam int CMD_DEBUG   = 5;

    // status halted bit
    localparam int STS_HALTED = 5;

    // reset values
    localparam logic [7:0]        CMD_RESET_VAL = 8'h08;
    localparam logic [7:0]        SOF_RESET_VAL = 8'h40;
    localparam logic [PORT_W-1:0] PORT_IN_RESET = 10'h100;
    localparam logic [PORT_W-1:0] PORT_KEEP     = 10'h0BB;

    typedef enum logic [1:0] {
        OP_FATAL = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_CMD    = 3'd0,
        REG_STS    = 3'd1,
        REG_INTR   = 3'd2,
        REG_FRNUM  = 3'd3,
        REG_FLBASE = 3'd4,
        REG_SOF    = 3'd5,
        REG_PORT   = 3'd6
    } reg_sel_t;

    // one classified request as it travels from front to back
    typedef struct packed {
        op_t                   op;
        reg_sel_t              sel;
        logic [PORT_SEL_W-1:0] port_sel;
        logic                  byte_rd;
        logic                  warn;
        logic [31:0]           wdata;
    } entry_t;

    // stored port bits to register view
    function automatic logic [15:0] port_read(input logic [PORT_W-1:0] b);
        port_read = {3'b000, b[9], 2'b00, b[8], b[7], 1'b1, b[6:0]};
    endfunction

    // port register write, change bits cleared by writing one
    function automatic logic [PORT_W-1:0] port_write(input logic [PORT_W-1:0] b,
                                                     input logic [15:0] v);
        logic [PORT_W-1:0] n;
        n = b & PORT_KEEP;
        if (v[12]) n[9] = 1'b1;
        if (v[9])  n[8] = 1'b1;
        if (v[6])  n[6] = 1'b1;
        if (v[3])  n[3] = 1'b0;
        if (v[2])  n[2] = 1'b1;
        if (v[1])  n[1] = 1'b0;
        port_write = n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/uhio_front.sv
// request decode: offset, size and value checks, reserved bit warnings
`default_nettype none

module uhio_front
    import uhio_pkg::*;
#(
    parameter int unsigned NUM_PORTS = NUM_PORTS_DEF
) (
    input  wire logic [15:0] io_base,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] address,
    input  wire logic [31:0] value,
    input  wire logic [2:0]  size,
    output entry_t           entry
);

    logic [7:0]  off;
    logic [2:0]  need;
    reg_sel_t    sel;
    logic [31:0] vmask;
    logic        is_port;
    logic        port_ok;
    logic        size_eq;
    logic        val_ok;
    logic        warn;

    assign off = address[7:0] - io_base[7:0];

    always_comb begin
        need = SIZE_NONE;
        sel  = REG_CMD;
        case (off)
            OFF_CMD:    begin need = SIZE_WORD;  sel = REG_CMD;    end
            OFF_STS:    begin need = SIZE_WORD;  sel = REG_STS;    end
            OFF_INTR:   begin need = SIZE_WORD;  sel = REG_INTR;   end
            OFF_FRNUM:  begin need = SIZE_WORD;  sel = REG_FRNUM;  end
            OFF_FLBASE: begin need = SIZE_DWORD; sel = REG_FLBASE; end
            OFF_SOF:    begin need = SIZE_BYTE;  sel = REG_SOF;    end
            OFF_PORT0:  begin need = SIZE_WORD;  sel = REG_PORT;   end
            OFF_PORT1:  begin need = SIZE_WORD;  sel = REG_PORT;   end
            default:    begin need = SIZE_NONE;  sel = REG_CMD;    end
        endcase
    end

    assign is_port = (need != SIZE_NONE) && (sel == REG_PORT);
    assign port_ok = {31'd0, off[1]} < NUM_PORTS[31:0];
    assign size_eq = (size == need);

    // write data cut to the register's own width
    always_comb begin
        case (need)
            SIZE_BYTE:  vmask = {24'd0, value[7:0]};
            SIZE_WORD:  vmask = {16'd0, value[15:0]};
            default:    vmask = value;
        endcase
    end

    always_comb begin
        val_ok = 1'b1;
        warn   = 1'b0;
        case (sel)
            REG_CMD: begin
                val_ok = !vmask[CMD_DEBUG];
                warn   = |vmask[15:8];
            end
            REG_STS:    warn = |vmask[15:6];
            REG_INTR:   warn = |vmask[15:4];
            REG_FRNUM:  warn = |vmask[15:11];
            REG_FLBASE: val_ok = (vmask[11:0] == 12'd0);
            REG_SOF:    warn = vmask[7];
            REG_PORT: begin
                val_ok = port_ok && !(vmask[5] || vmask[4] || vmask[0]);
                warn   = !vmask[7];
            end
            default: begin
                val_ok = 1'b1;
                warn   = 1'b0;
            end
        endcase
    end

    always_comb begin
        entry.op       = OP_FATAL;
        entry.sel      = sel;
        entry.port_sel = off[1];
        entry.byte_rd  = (size == SIZE_BYTE);
        entry.warn     = warn;
        entry.wdata    = vmask;
        case (kind)
            KIND_TICK: entry.op = OP_TICK;
            KIND_READ: begin
                if ((need != SIZE_NONE) && (size_eq || (is_port && size == SIZE_BYTE))
                    && (!is_port || port_ok)) begin
                    entry.op = OP_READ;
                end
            end
            KIND_WRITE: begin
                if ((need != SIZE_NONE) && size_eq && val_ok) begin
                    entry.op = OP_WRITE;
                end
            end
            default: entry.op = OP_FATAL;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/uhio_queue.sv
// two-entry queue of decoded requests between front and back
`default_nettype none

module uhio_queue
    import uhio_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output logic        full,
    output logic        valid,
    output entry_t      head
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/uhio_back.sv
// register file, tick handling and the result register
`default_nettype none

module uhio_back
    import uhio_pkg::*;
#(
    parameter int unsigned NUM_PORTS   = NUM_PORTS_DEF,
    parameter int unsigned RESET_TICKS = RESET_TICKS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire entry_t      q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_rdata,
    output logic [1:0]       m_status
);

    logic [7:0]         cmd_reg,    cmd_next;
    logic [5:0]         sts_reg,    sts_next;
    logic [3:0]         intr_reg,   intr_next;
    logic [15:0]        frnum_reg,  frnum_next;
    logic [31:0]        flbase_reg, flbase_next;
    logic [7:0]         sof_reg,    sof_next;
    logic [PORT_W-1:0]  port_reg   [NUM_PORTS];
    logic [PORT_W-1:0]  port_next  [NUM_PORTS];
    logic [TICKS_W-1:0] ticks_reg,  ticks_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        rdata_reg,  rdata_next;
    logic [1:0]         status_reg, status_next;
    logic               hreset;
    logic [15:0]        pview;

    assign q_pop    = q_valid && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_rdata  = rdata_reg;
    assign m_status = status_reg;

    always_comb begin
        cmd_next    = cmd_reg;
        sts_next    = sts_reg;
        intr_next   = intr_reg;
        frnum_next  = frnum_reg;
        flbase_next = flbase_reg;
        sof_next    = sof_reg;
        ticks_next  = ticks_reg;
        for (int i = 0; i < NUM_PORTS; i++) begin
            port_next[i] = port_reg[i];
        end
        rdata_next  = rdata_reg;
        status_next = status_reg;
        hreset      = 1'b0;
        pview       = 16'd0;
        m_valid_next = q_pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        if (q_pop) begin
            rdata_next  = 32'd0;
            status_next = ST_OK;
            case (q_head.op)
                OP_TICK: begin
                    frnum_next = {6'd0, frnum_reg[9:0] + 10'd1};
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (ticks_reg != '0) begin
                            port_next[i] = PORT_IN_RESET;
                        end else begin
                            port_next[i] = port_reg[i] & ~PORT_IN_RESET;
                        end
                    end
                    if (ticks_reg != '0) begin
                        ticks_next = ticks_reg - TICKS_W'(1);
                    end
                    if (!cmd_reg[CMD_RUN]) begin
                        sts_next[STS_HALTED] = 1'b1;
                    end
                end
                OP_READ: begin
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (q_head.port_sel == PORT_SEL_W'(i)) begin
                            pview = port_read(port_reg[i]);
                        end
                    end
                    case (q_head.sel)
                        REG_CMD:    rdata_next = {24'd0, cmd_reg};
                        REG_STS:    rdata_next = {26'd0, sts_reg};
                        REG_INTR:   rdata_next = {28'd0, intr_reg};
                        REG_FRNUM:  rdata_next = {16'd0, frnum_reg};
                        REG_FLBASE: rdata_next = flbase_reg;
                        REG_SOF:    rdata_next = {24'd0, sof_reg};
                        REG_PORT: begin
                            rdata_next = q_head.byte_rd ? {24'd0, pview[7:0]}
                                                        : {16'd0, pview};
                        end
                        default:    rdata_next = 32'd0;
                    endcase
                end
                OP_WRITE: begin
                    status_next = q_head.warn ? ST_WARN : ST_OK;
                    case (q_head.sel)
                        REG_CMD: begin
                            cmd_next = q_head.wdata[7:0];
                            if (q_head.wdata[CMD_GRESET]) begin
                                ticks_next = TICKS_W'(RESET_TICKS);
                            end
                            hreset = q_head.wdata[CMD_HRESET];
                        end
                        REG_STS:    sts_next  = sts_reg & ~q_head.wdata[5:0];
                        REG_INTR:   intr_next = q_head.wdata[3:0];
                        REG_FRNUM: begin
                            if (sts_reg[STS_HALTED]) begin
                                frnum_next = q_head.wdata[15:0];
                            end
                        end
                        REG_FLBASE: flbase_next = q_head.wdata;
                        REG_SOF:    sof_next    = q_head.wdata[7:0];
                        REG_PORT: begin
                            // suspend request while globally suspended
                            if (q_head.wdata[12] && cmd_reg[CMD_SUSPEND]) begin
                                status_next = ST_WARN;
                            end
                            for (int i = 0; i < NUM_PORTS; i++) begin
                                if (q_head.port_sel == PORT_SEL_W'(i)) begin
                                    port_next[i] = port_write(port_reg[i],
                                                              q_head.wdata[15:0]);
                                end
                            end
                        end
                        default: status_next = ST_FATAL;
                    endcase
                end
                default: status_next = ST_FATAL;
            endcase
        end

        // host reset wins over everything the same write did
        if (hreset) begin
            cmd_next    = CMD_RESET_VAL;
            sts_next    = 6'd0;
            intr_next   = 4'd0;
            frnum_next  = 16'd0;
            flbase_next = 32'd0;
            sof_next    = SOF_RESET_VAL;
            ticks_next  = '0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                port_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg     <= CMD_RESET_VAL;
            sts_reg     <= 6'd0;
            intr_reg    <= 4'd0;
            frnum_reg   <= 16'd0;
            flbase_reg  <= 32'd0;
            sof_reg     <= SOF_RESET_VAL;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                port_reg[i] <= '0;
            end
        end else begin
            cmd_reg     <= cmd_next;
            sts_reg     <= sts_next;
            intr_reg    <= intr_next;
            frnum_reg   <= frnum_next;
            flbase_reg  <= flbase_next;
            sof_reg     <= sof_next;
            ticks_reg   <= ticks_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NUM_PORTS; i++) begin
                port_reg[i] <= port_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// File: rtl/usb_host_io_registers.sv
// top level of the usb host controller i/o register block
//
//  channel   direction  tdata                                   tuser
//  s_*       in         address[15:0] value[47:16] size[50:48]  kind[1:0]
//  m_*       out        read_data[31:0]                         status[1:0]
//  cfg_*     in         io_base on cfg_wr_data[15:0]            -
//
// one request per cycle sustained while results are taken; a result is offered
//   once its request has passed the queue register, then the result register
// the front decodes into a two-entry queue, the back updates the register
//   file and loads the result register, each stalling on its own
// a stalled result holds while the queue keeps taking requests until full
// synchronous active-low reset sets every register but the result data, status and queue storage at once
// io_base only changes on a configuration write or aresetn, never on host reset
`default_nettype none

module usb_host_io_registers
    import uhio_pkg::*;
#(
    parameter int unsigned NUM_PORTS   = NUM_PORTS_DEF,
    parameter int unsigned RESET_TICKS = RESET_TICKS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: io base address
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // address[15:0], value[47:16], size[50:48], zero
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // read_data[31:0]
    output logic [1:0]       m_tuser    // status[1:0]
);

    logic [15:0] io_base_reg;
    entry_t      dec_entry;
    entry_t      q_head;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        s_push;

    // base address register; users must write it only while idle, not enforced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            io_base_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            io_base_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !q_full;
    assign s_push   = s_tvalid && s_tready;

    // front: classify the request
    uhio_front #(
        .NUM_PORTS (NUM_PORTS)
    ) u_front (
        .io_base (io_base_reg),
        .kind    (s_tuser),
        .address (s_tdata[15:0]),
        .value   (s_tdata[47:16]),
        .size    (s_tdata[50:48]),
        .entry   (dec_entry)
    );

    // decoupling queue
    uhio_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_push),
        .push_entry (dec_entry),
        .pop        (q_pop),
        .full       (q_full),
        .valid      (q_valid),
        .head       (q_head)
    );

    // back: register file and result register
    uhio_back #(
        .NUM_PORTS   (NUM_PORTS),
        .RESET_TICKS (RESET_TICKS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_rdata  (m_tdata),
        .m_status (m_tuser)
    );

    // writes, ticks and failed requests return zero data
    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && (q_head.op != OP_READ) |=> (m_tdata == 32'd0))
        else $error("non-read result carries data");

    // reads never raise a reserved-bits warning
    a_read_no_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && (q_head.op == OP_READ) |=> (m_tuser != ST_WARN))
        else $error("read result flagged with warning");

    // back-pressure on the request side only when the queue holds work
    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("request side stalled with empty queue");

endmodule

`default_nettype wire
